/* sv/mmpr_pkg.sv */
// Package for the motor motion profile ramp block.
// State codes, field codes, register indexes and speed helpers.
// No dependencies.
`default_nettype none
package mmpr_pkg;

   typedef enum logic [15:0] {
      ST_IDLE     = 16'h0001,
      ST_CMD_MUL  = 16'h0002,
      ST_CMD_CHK  = 16'h0004,
      ST_DIV      = 16'h0008,
      ST_CMD_SET  = 16'h0010,
      ST_T_TRAV   = 16'h0020,
      ST_T_DIST   = 16'h0040,
      ST_T_PHASE  = 16'h0080,
      ST_T_PSQ    = 16'h0100,
      ST_T_PMUL   = 16'h0200,
      ST_T_SQT    = 16'h0400,
      ST_T_SQP    = 16'h0800,
      ST_T_SAPPLY = 16'h1000,
      ST_T_TIME   = 16'h2000,
      ST_T_RAMP   = 16'h4000,
      ST_OUT      = 16'h8000
   } state_type;

   localparam logic       KIND_CMD  = 1'b0;
   localparam logic       KIND_TICK = 1'b1;

   localparam logic [1:0] MODE_CONT = 2'd0;
   localparam logic [1:0] MODE_DIST = 2'd1;
   localparam logic [1:0] MODE_TIME = 2'd2;

   localparam logic [2:0] REG_RAMP_INTERVAL = 3'd0;
   localparam logic [2:0] REG_RAMP_STEP     = 3'd1;
   localparam logic [2:0] REG_MIN_SPEED     = 3'd2;
   localparam logic [2:0] REG_FORWARD_LEVEL = 3'd3;
   localparam logic [2:0] REG_ENC_REVERSE   = 3'd4;

   localparam logic [6:0] MAX_SPEED = 7'd100;

   // duty = mag*255/100 as mag*255*ceil(2^19/100) >> 19, exact for mag <= 100
   localparam logic [27:0] PWM_RECIP = 28'd1336965;
   localparam int          PWM_SHIFT = 19;

   function automatic logic [6:0] spd_mag(input logic signed [7:0] v);
      logic [7:0] n;
      n = 8'(-v);
      return v[7] ? n[6:0] : v[6:0];
   endfunction

endpackage
`default_nettype wire

/* sv/motor_motion_profile_ramp.sv */
// Trapezoidal speed profile for one motor channel, top level.
// Sequencer around one shared multiplier, a restoring divider and compare logic.
// Depends on mmpr_pkg.
//
// One beat in, one beat out. A beat is taken only in idle; the block then stalls
// its input until the result beat is taken. In distance deceleration a tick finds
// the floor square root bit by bit over 7 bits, with up to two passes through the
// shared multiplier per bit. A time mode command that cannot reach its requested
// speed runs the restoring divider over the 31 bits of the move amount.
`default_nettype none
module motor_motion_profile_ramp #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire                req_kind,
   input  wire                req_direction,
   input  wire  [6:0]         req_speed_pct,
   input  wire  [1:0]         req_move_mode,
   input  wire  [30:0]        req_move_amount,
   input  wire  signed [31:0] req_encoder_count,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic signed [7:0]  rsp_speed,
   output logic [7:0]         rsp_pwm_duty,
   output logic               rsp_dir_level,
   output logic               rsp_distance_active,
   output logic               rsp_time_active,
   output logic               rsp_decel_phase,
   input  wire                csr_psel,
   input  wire                csr_penable,
   input  wire                csr_pwrite,
   input  wire  [4:0]         csr_paddr,
   input  wire  [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import mmpr_pkg::*;

   localparam int CW = COUNT_WIDTH;
   localparam int TW = (COUNT_WIDTH > 31) ? COUNT_WIDTH : 31;
   localparam int PW = TW + 14;

   state_type state_ff, state_in;

   logic [9:0] ramp_ff, ramp_in;
   logic [6:0] step_ff, step_in;
   logic [6:0] minspd_ff, minspd_in;
   logic       fwd_ff, fwd_in;
   logic       encrev_ff, encrev_in;

   logic signed [7:0] cur_ff, cur_in, tgt_ff, tgt_in, reqs_ff, reqs_in;
   logic dist_ff, dist_in, timed_ff, timed_in, phase_ff, phase_in;
   logic [CW-1:0] start_ff, start_in, accel_ff, accel_in;
   logic [TW-1:0] total_ff, total_in, decel_ff, decel_in;
   logic [6:0]    peak_ff, peak_in;
   logic [31:0]   tstart_ff, tstart_in, dur_ff, dur_in, dtime_ff, dtime_in;
   logic [31:0]   ms_ff, ms_in, lramp_ff, lramp_in;

   logic          dir_ff, dir_in;
   logic [6:0]    spd_ff, spd_in;
   logic [30:0]   amount_ff, amount_in;
   logic [CW-1:0] enc_ff, enc_in;

   logic [CW-1:0] trav_ff, trav_in;
   logic [TW-1:0] remd_ff, remd_in;
   logic [PW-1:0] p_ff, p_in;
   logic [13:0]   sq_ff, sq_in;
   logic [6:0]    s_ff, s_in;
   logic [2:0]    bit_ff, bit_in;
   logic [10:0]   div_r_ff, div_r_in;
   logic [30:0]   div_q_ff, div_q_in;
   logic [4:0]    div_cnt_ff, div_cnt_in;

   logic [TW-1:0] mul_a;
   logic [13:0]   mul_b;
   logic [PW-1:0] mul_out;

   assign mul_out = PW'(mul_a) * PW'(mul_b);

   logic        accept;
   logic        csr_wr;
   logic [63:0] enc_sx;
   logic [CW-1:0] enc_cw;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_pready = 1'b1;
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign enc_sx    = {{32{req_encoder_count[31]}}, req_encoder_count};
   assign enc_cw    = enc_sx[CW-1:0];

   always_comb begin
      csr_prdata = 32'd0;
      case (csr_paddr[4:2])
         REG_RAMP_INTERVAL: csr_prdata = {22'd0, ramp_ff};
         REG_RAMP_STEP:     csr_prdata = {25'd0, step_ff};
         REG_MIN_SPEED:     csr_prdata = {25'd0, minspd_ff};
         REG_FORWARD_LEVEL: csr_prdata = {31'd0, fwd_ff};
         REG_ENC_REVERSE:   csr_prdata = {31'd0, encrev_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   logic [6:0]    spd_cl, mag_c, mag_r, t_cand, lo_spd, s_val;
   logic signed [7:0] reqs_n;
   logic [CW-1:0] d_cnt, acc_n;
   logic [TW-1:0] trav_ext, limit;
   logic [31:0]   need32, elapsed, since_ramp;
   logic [11:0]   r_sh, divisor;
   logic          qbit, ph_set;
   logic signed [8:0] cs9, ts9, st9;

   always_comb begin
      state_in   = state_ff;
      ramp_in    = ramp_ff;
      step_in    = step_ff;
      minspd_in  = minspd_ff;
      fwd_in     = fwd_ff;
      encrev_in  = encrev_ff;
      cur_in     = cur_ff;
      tgt_in     = tgt_ff;
      reqs_in    = reqs_ff;
      dist_in    = dist_ff;
      timed_in   = timed_ff;
      phase_in   = phase_ff;
      start_in   = start_ff;
      accel_in   = accel_ff;
      total_in   = total_ff;
      decel_in   = decel_ff;
      peak_in    = peak_ff;
      tstart_in  = tstart_ff;
      dur_in     = dur_ff;
      dtime_in   = dtime_ff;
      ms_in      = ms_ff;
      lramp_in   = lramp_ff;
      dir_in     = dir_ff;
      spd_in     = spd_ff;
      amount_in  = amount_ff;
      enc_in     = enc_ff;
      trav_in    = trav_ff;
      remd_in    = remd_ff;
      p_in       = p_ff;
      sq_in      = sq_ff;
      s_in       = s_ff;
      bit_in     = bit_ff;
      div_r_in   = div_r_ff;
      div_q_in   = div_q_ff;
      div_cnt_in = div_cnt_ff;
      mul_a      = '0;
      mul_b      = '0;

      spd_cl   = (req_speed_pct > MAX_SPEED) ? MAX_SPEED : req_speed_pct;
      reqs_n   = req_direction ? signed'({1'b0, spd_cl}) : signed'(8'(-{1'b0, spd_cl}));
      mag_c    = spd_mag(cur_ff);
      mag_r    = spd_mag(reqs_ff);
      t_cand   = s_ff | (7'd1 << bit_ff);
      lo_spd   = (minspd_ff > MAX_SPEED) ? MAX_SPEED : minspd_ff;
      s_val    = (s_ff < lo_spd) ? lo_spd : s_ff;
      d_cnt    = enc_ff - start_ff;
      trav_ext = TW'(trav_ff);
      acc_n    = accel_ff;
      limit    = trav_ext;
      ph_set   = 1'b0;
      need32   = 32'(p_ff[16:0]);
      elapsed  = ms_ff - tstart_ff;
      since_ramp = ms_ff - lramp_ff;
      divisor  = {1'b0, ramp_ff, 1'b0};
      r_sh     = {div_r_ff, div_q_ff[30]};
      qbit     = (r_sh >= divisor);
      cs9      = {cur_ff[7], cur_ff};
      ts9      = {tgt_ff[7], tgt_ff};
      st9      = signed'({2'b00, step_ff});

      if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_RAMP_INTERVAL: ramp_in   = csr_pwdata[9:0];
            REG_RAMP_STEP:     step_in   = csr_pwdata[6:0];
            REG_MIN_SPEED:     minspd_in = csr_pwdata[6:0];
            REG_FORWARD_LEVEL: fwd_in    = csr_pwdata[0];
            REG_ENC_REVERSE:   encrev_in = csr_pwdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dir_in    = req_direction;
               spd_in    = spd_cl;
               amount_in = req_move_amount;
               enc_in    = encrev_ff ? CW'(CW'(0) - enc_cw) : enc_cw;
               if (req_kind == KIND_TICK) begin
                  state_in = ST_T_TRAV;
               end else begin
                  reqs_in = reqs_n;
                  case (req_move_mode)
                     MODE_DIST: begin
                        timed_in = 1'b0;
                        total_in = TW'(req_move_amount);
                        start_in = encrev_ff ? CW'(CW'(0) - enc_cw) : enc_cw;
                        accel_in = '0;
                        phase_in = 1'b0;
                        tgt_in   = reqs_n;
                        dist_in  = 1'b1;
                        state_in = ST_OUT;
                     end
                     MODE_TIME: state_in = ST_CMD_MUL;
                     default: begin
                        dist_in  = 1'b0;
                        timed_in = 1'b0;
                        tgt_in   = reqs_n;
                        state_in = ST_OUT;
                     end
                  endcase
               end
            end
         end
         ST_CMD_MUL: begin
            mul_a    = TW'(spd_ff);
            mul_b    = 14'(ramp_ff);
            p_in     = mul_out;
            state_in = ST_CMD_CHK;
         end
         ST_CMD_CHK: begin
            if (32'(amount_ff) >= {need32[30:0], 1'b0}) begin
               peak_in  = spd_ff;
               dtime_in = 32'(amount_ff) - need32;
               state_in = ST_CMD_SET;
            end else begin
               div_r_in   = '0;
               div_q_in   = amount_ff;
               div_cnt_in = 5'd30;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            div_r_in   = qbit ? 11'(r_sh - divisor) : r_sh[10:0];
            div_q_in   = {div_q_ff[29:0], qbit};
            div_cnt_in = div_cnt_ff - 5'd1;
            if (div_cnt_ff == 5'd0) begin
               peak_in  = div_q_in[6:0];
               dtime_in = 32'(amount_ff[30:1]);
               state_in = ST_CMD_SET;
            end
         end
         ST_CMD_SET: begin
            dist_in   = 1'b0;
            dur_in    = 32'(amount_ff);
            tstart_in = ms_ff;
            tgt_in    = dir_ff ? signed'({1'b0, peak_ff}) : signed'(8'(-{1'b0, peak_ff}));
            timed_in  = 1'b1;
            state_in  = ST_OUT;
         end
         ST_T_TRAV: begin
            trav_in  = d_cnt[CW-1] ? CW'(~d_cnt + 1'b1) : d_cnt;
            ms_in    = ms_ff + 32'd1;
            state_in = ST_T_DIST;
         end
         ST_T_DIST: begin
            state_in = ST_T_TIME;
            if (dist_ff) begin
               if (trav_ext >= total_ff) begin
                  tgt_in  = '0;
                  cur_in  = '0;
                  dist_in = 1'b0;
               end else begin
                  remd_in  = total_ff - trav_ext;
                  state_in = ST_T_PHASE;
               end
            end
         end
         ST_T_PHASE: begin
            if (!phase_ff) begin
               if (mag_c >= mag_r && accel_ff == '0) acc_n = trav_ff;
               accel_in = acc_n;
               limit    = (acc_n != '0) ? TW'(acc_n) : trav_ext;
               if (remd_ff <= limit) begin
                  ph_set   = 1'b1;
                  phase_in = 1'b1;
                  decel_in = remd_ff;
                  peak_in  = mag_c;
               end
            end
            if (ph_set) begin
               state_in = ST_T_PSQ;
            end else if (phase_ff) begin
               if (decel_ff == '0) begin
                  s_in     = (peak_ff > MAX_SPEED) ? MAX_SPEED : peak_ff;
                  state_in = ST_T_SAPPLY;
               end else begin
                  state_in = ST_T_PSQ;
               end
            end else begin
               state_in = ST_T_TIME;
            end
         end
         ST_T_PSQ: begin
            mul_a    = TW'(peak_ff);
            mul_b    = 14'(peak_ff);
            sq_in    = mul_out[13:0];
            state_in = ST_T_PMUL;
         end
         ST_T_PMUL: begin
            mul_a    = remd_ff;
            mul_b    = sq_ff;
            p_in     = mul_out;
            s_in     = '0;
            bit_in   = 3'd6;
            state_in = ST_T_SQT;
         end
         ST_T_SQT: begin
            if (t_cand > MAX_SPEED) begin
               bit_in = bit_ff - 3'd1;
               if (bit_ff == 3'd0) state_in = ST_T_SAPPLY;
            end else begin
               mul_a    = TW'(t_cand);
               mul_b    = 14'(t_cand);
               sq_in    = mul_out[13:0];
               state_in = ST_T_SQP;
            end
         end
         ST_T_SQP: begin
            mul_a  = decel_ff;
            mul_b  = sq_ff;
            if (mul_out <= p_ff) s_in = t_cand;
            bit_in = bit_ff - 3'd1;
            state_in = (bit_ff == 3'd0) ? ST_T_SAPPLY : ST_T_SQT;
         end
         ST_T_SAPPLY: begin
            cur_in   = reqs_ff[7] ? signed'(8'(-{1'b0, s_val})) : signed'({1'b0, s_val});
            tgt_in   = cur_in;
            state_in = ST_T_TIME;
         end
         ST_T_TIME: begin
            if (timed_ff) begin
               if (elapsed >= dur_ff) begin
                  tgt_in   = '0;
                  cur_in   = '0;
                  timed_in = 1'b0;
               end else if (elapsed >= dtime_ff) begin
                  tgt_in = '0;
               end
            end
            state_in = ST_T_RAMP;
         end
         ST_T_RAMP: begin
            if (since_ramp >= 32'(ramp_ff)) begin
               lramp_in = ms_ff;
               if (!(dist_ff && phase_ff)) begin
                  if (cs9 < ts9)
                     cur_in = (ts9 - cs9 > st9) ? 8'(cs9 + st9) : tgt_ff;
                  else if (cs9 > ts9)
                     cur_in = (cs9 - ts9 > st9) ? 8'(cs9 - st9) : tgt_ff;
               end
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ramp_ff   <= 10'd20;
         step_ff   <= 7'd1;
         minspd_ff <= 7'd10;
         fwd_ff    <= 1'b1;
         encrev_ff <= 1'b0;
         cur_ff    <= '0;
         tgt_ff    <= '0;
         reqs_ff   <= '0;
         dist_ff   <= 1'b0;
         timed_ff  <= 1'b0;
         phase_ff  <= 1'b0;
         start_ff  <= '0;
         accel_ff  <= '0;
         total_ff  <= '0;
         decel_ff  <= '0;
         peak_ff   <= '0;
         tstart_ff <= '0;
         dur_ff    <= '0;
         dtime_ff  <= '0;
         ms_ff     <= '0;
         lramp_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         ramp_ff   <= ramp_in;
         step_ff   <= step_in;
         minspd_ff <= minspd_in;
         fwd_ff    <= fwd_in;
         encrev_ff <= encrev_in;
         cur_ff    <= cur_in;
         tgt_ff    <= tgt_in;
         reqs_ff   <= reqs_in;
         dist_ff   <= dist_in;
         timed_ff  <= timed_in;
         phase_ff  <= phase_in;
         start_ff  <= start_in;
         accel_ff  <= accel_in;
         total_ff  <= total_in;
         decel_ff  <= decel_in;
         peak_ff   <= peak_in;
         tstart_ff <= tstart_in;
         dur_ff    <= dur_in;
         dtime_ff  <= dtime_in;
         ms_ff     <= ms_in;
         lramp_ff  <= lramp_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff     <= dir_in;
      spd_ff     <= spd_in;
      amount_ff  <= amount_in;
      enc_ff     <= enc_in;
      trav_ff    <= trav_in;
      remd_ff    <= remd_in;
      p_ff       <= p_in;
      sq_ff      <= sq_in;
      s_ff       <= s_in;
      bit_ff     <= bit_in;
      div_r_ff   <= div_r_in;
      div_q_ff   <= div_q_in;
      div_cnt_ff <= div_cnt_in;
   end

   logic [27:0] pwm_prod;
   assign pwm_prod = 28'(mag_c) * PWM_RECIP;

   assign rsp_valid           = (state_ff == ST_OUT);
   assign rsp_speed           = cur_ff;
   assign rsp_pwm_duty        = pwm_prod[PWM_SHIFT+7:PWM_SHIFT];
   assign rsp_dir_level       = cur_ff[7] ? ~fwd_ff : fwd_ff;
   assign rsp_distance_active = dist_ff;
   assign rsp_time_active     = timed_ff;
   assign rsp_decel_phase     = dist_ff && phase_ff;

endmodule
`default_nettype wire

/* tb/tb.sv */
// Testbench for motor_motion_profile_ramp: directed table, then random command/tick beats.
// Results are checked field by field against an in-bench profile predictor.
// Depends on mmpr_pkg and motor_motion_profile_ramp.
`default_nettype none
module tb;
   import mmpr_pkg::*;

   typedef struct packed {
      logic        kind;
      logic        direction;
      logic [6:0]  speed_pct;
      logic [1:0]  move_mode;
      logic [30:0] move_amount;
      logic [31:0] encoder_count;
   } beat_type;

   typedef struct packed {
      logic [7:0] speed;
      logic [7:0] pwm_duty;
      logic       dir_level;
      logic       distance_active;
      logic       time_active;
      logic       decel_phase;
   } resp_type;

   typedef struct {
      beat_type b;
      bit       has_exp;
      resp_type exp_r;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   wire  req_stall;
   logic req_kind = 0, req_direction = 0;
   logic [6:0] req_speed_pct = 0;
   logic [1:0] req_move_mode = 0;
   logic [30:0] req_move_amount = 0;
   logic signed [31:0] req_encoder_count = 0;
   wire rsp_valid;
   logic rsp_stall = 0;
   wire signed [7:0] rsp_speed;
   wire [7:0] rsp_pwm_duty;
   wire rsp_dir_level, rsp_distance_active, rsp_time_active, rsp_decel_phase;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   wire [31:0] csr_prdata;
   wire csr_pready;

   motor_motion_profile_ramp uut (.*);

   always #2 clock = ~clock;

   // predictor state
   int unsigned p_interval, p_step, p_min;
   bit p_fwd, p_rev;
   int cur_spd, tgt_spd, req_spd;
   bit dist_on, time_on, decel_on;
   longint unsigned start_cnt, tot_dist, acc_dist, dec_dist;
   int unsigned peak;
   int unsigned t_start, t_dur, t_decel, ms_cnt, last_ramp;

   resp_type expected_q[$];
   int errors = 0;
   int cycles = 0;
   bit quiet = 0;
   int stall_left = 0;
   longint unsigned enc_walk;

   task automatic report(input string what, input int got, input int want);
      errors++;
      $display("mismatch %s: got %0d want %0d", what, got, want);
   endtask

   function automatic int mag(input int v);
      return v < 0 ? -v : v;
   endfunction

   function automatic int sqrt_speed(input longint unsigned rem, input longint unsigned dec,
                                     input int unsigned pk);
      logic [127:0] rhs, lhs;
      int s;
      if (dec == 0) return pk > 100 ? 100 : pk;
      rhs = 128'(rem) * 128'(pk * pk);
      for (s = 100; s > 0; s--) begin
         lhs = 128'(dec) * 128'(s * s);
         if (lhs <= rhs) break;
      end
      return s;
   endfunction

   task automatic profile_reset();
      p_interval = 20; p_step = 1; p_min = 10; p_fwd = 1; p_rev = 0;
      cur_spd = 0; tgt_spd = 0; req_spd = 0;
      dist_on = 0; time_on = 0; decel_on = 0;
      start_cnt = 0; tot_dist = 0; acc_dist = 0; dec_dist = 0; peak = 0;
      t_start = 0; t_dur = 0; t_decel = 0; ms_cnt = 0; last_ramp = 0;
   endtask

   function automatic resp_type profile_step(input beat_type b);
      longint unsigned enc, d, trav, rem;
      int dir, spd, s, lo, a;
      int unsigned need, el;
      resp_type r;
      enc = 64'(32'(p_rev ? -$signed(b.encoder_count) : $signed(b.encoder_count)));
      if (b.kind == KIND_TICK) begin
         ms_cnt++;
         if (dist_on) begin
            d = (enc - start_cnt) & 64'hFFFF_FFFF;
            trav = d[31] ? ((~d) & 64'hFFFF_FFFF) + 1 : d;
            if (trav >= tot_dist) begin
               tgt_spd = 0; cur_spd = 0; dist_on = 0;
            end else begin
               rem = tot_dist - trav;
               if (!decel_on) begin
                  if (mag(cur_spd) >= mag(req_spd) && acc_dist == 0) acc_dist = trav;
                  if (acc_dist > 0 ? rem <= acc_dist : rem <= trav) begin
                     decel_on = 1; dec_dist = rem; peak = mag(cur_spd);
                  end
               end
               if (decel_on) begin
                  s = sqrt_speed(rem, dec_dist, peak);
                  lo = p_min > 100 ? 100 : p_min;
                  if (s < lo) s = lo;
                  cur_spd = req_spd >= 0 ? s : -s;
                  tgt_spd = cur_spd;
               end
            end
         end
         if (time_on) begin
            el = ms_cnt - t_start;
            if (el >= t_dur) begin
               tgt_spd = 0; cur_spd = 0; time_on = 0;
            end else if (el >= t_decel) tgt_spd = 0;
         end
         if (ms_cnt - last_ramp >= p_interval) begin
            last_ramp = ms_cnt;
            if (!(dist_on && decel_on)) begin
               if (cur_spd < tgt_spd)
                  cur_spd = (tgt_spd - cur_spd > int'(p_step)) ? cur_spd + p_step : tgt_spd;
               else if (cur_spd > tgt_spd)
                  cur_spd = (cur_spd - tgt_spd > int'(p_step)) ? cur_spd - p_step : tgt_spd;
            end
         end
         if (cur_spd > 100) cur_spd = 100;
         if (cur_spd < -100) cur_spd = -100;
      end else begin
         dir = b.direction ? 1 : -1;
         spd = b.speed_pct > 100 ? 100 : b.speed_pct;
         req_spd = spd * dir;
         if (b.move_mode == MODE_DIST) begin
            time_on = 0; tot_dist = b.move_amount; start_cnt = enc & 64'hFFFF_FFFF;
            acc_dist = 0; decel_on = 0; tgt_spd = req_spd; dist_on = 1;
         end else if (b.move_mode == MODE_TIME) begin
            need = spd * p_interval;
            dist_on = 0;
            if (64'(b.move_amount) >= 2 * 64'(need)) begin
               peak = spd; t_decel = b.move_amount - need;
            end else begin
               peak = (p_interval == 0) ? 0 : b.move_amount / (2 * p_interval);
               t_decel = b.move_amount / 2;
            end
            t_dur = b.move_amount; t_start = ms_cnt;
            tgt_spd = int'(peak) * dir; time_on = 1;
         end else begin
            dist_on = 0; time_on = 0; tgt_spd = req_spd;
         end
      end
      a = mag(cur_spd);
      r.speed = 8'(cur_spd);
      r.pwm_duty = 8'(a * 255 / 100);
      r.dir_level = cur_spd >= 0 ? p_fwd : ~p_fwd;
      r.distance_active = dist_on;
      r.time_active = time_on;
      r.decel_phase = dist_on && decel_on;
      return r;
   endfunction

   task automatic csr_write(input logic [2:0] idx, input int unsigned val);
      @(negedge clock);
      csr_psel = 1; csr_pwrite = 1; csr_paddr = 5'(idx) << 2; csr_pwdata = val;
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0;
      case (idx)
         REG_RAMP_INTERVAL: p_interval = val & 10'h3FF;
         REG_RAMP_STEP:     p_step = val & 7'h7F;
         REG_MIN_SPEED:     p_min = val & 7'h7F;
         REG_FORWARD_LEVEL: p_fwd = val[0];
         REG_ENC_REVERSE:   p_rev = val[0];
         default: ;
      endcase
   endtask

   task automatic send(input beat_type b, input bit has_exp, input resp_type want);
      resp_type r;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      {req_kind, req_direction, req_speed_pct, req_move_mode, req_move_amount,
       req_encoder_count} = b;
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      r = profile_step(b);
      if (has_exp && r != want) report("table row vs predictor", int'(r), int'(want));
      expected_q.push_back(r);
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic drain();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (!reset) begin
         if (stall_left == 0 && !quiet && $urandom_range(0, 6) == 0)
            stall_left = $urandom_range(1, 4);
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left = stall_left - 1;
      end
   end

   always @(posedge clock) begin
      resp_type got, want;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_speed, rsp_pwm_duty, rsp_dir_level, rsp_distance_active,
                rsp_time_active, rsp_decel_phase};
         if (expected_q.size() == 0) report("unexpected beat", int'(got), 0);
         else begin
            want = expected_q.pop_front();
            if (got.speed != want.speed)
               report("speed", $signed(got.speed), $signed(want.speed));
            if (got.pwm_duty != want.pwm_duty) report("pwm_duty", got.pwm_duty, want.pwm_duty);
            if (got.dir_level != want.dir_level) report("dir_level", got.dir_level, want.dir_level);
            if (got.distance_active != want.distance_active)
               report("distance_active", got.distance_active, want.distance_active);
            if (got.time_active != want.time_active)
               report("time_active", got.time_active, want.time_active);
            if (got.decel_phase != want.decel_phase)
               report("decel_phase", got.decel_phase, want.decel_phase);
         end
      end
      if (cycles > 3000000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic beat_type cmd(input bit dir, input int spd, input logic [1:0] mode,
                                    input int unsigned amt, input int enc);
      return {KIND_CMD, dir, 7'(spd), mode, 31'(amt), 32'(enc)};
   endfunction

   function automatic beat_type tick(input int enc);
      return {KIND_TICK, 1'b0, 7'd0, 2'd0, 31'd0, 32'(enc)};
   endfunction

   row_type rows[$];
   localparam resp_type IDLE_R  = {8'd0, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0};
   localparam resp_type TIMED_R = {8'd0, 8'd0, 1'b1, 1'b0, 1'b1, 1'b0};

   task automatic random_run(input int n);
      beat_type b;
      int k, m;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         if (k < 6) begin
            m = $urandom_range(0, 9);
            b = cmd(1'($urandom), (m == 0) ? $urandom_range(0, 127) : $urandom_range(0, 100),
                    (m == 1) ? 2'd3 : 2'($urandom_range(0, 2)),
                    (m == 2) ? $urandom : $urandom_range(0, 400),
                    32'(enc_walk));
         end else begin
            if (k < 8) enc_walk = $urandom;
            else if ($urandom_range(0, 1)) enc_walk += $urandom_range(0, 6);
            b = tick(32'(enc_walk));
         end
         send(b, 0, '0);
      end
   endtask

   initial begin
      profile_reset();
      enc_walk = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;
      rows.push_back('{tick(0), 1, IDLE_R});
      rows.push_back('{cmd(1, 127, MODE_CONT, 0, 0), 1, IDLE_R});
      rows.push_back('{cmd(0, 100, 2'd3, 31'h7FFF_FFFF, -32'sd2147483648), 1, IDLE_R});
      rows.push_back('{cmd(1, 0, MODE_TIME, 0, 32'h7FFF_FFFF), 1, TIMED_R});
      rows.push_back('{cmd(1, 50, MODE_TIME, 100, 0), 1, TIMED_R});
      rows.push_back('{cmd(0, 60, MODE_TIME, 31'h7FFF_FFFF, 0), 1, TIMED_R});
      rows.push_back('{cmd(1, 80, MODE_DIST, 30, 5), 0, '0});
      for (int i = 0; i < 18; i++) rows.push_back('{tick(5 + 2 * i), 0, '0});
      foreach (rows[i]) send(rows[i].b, rows[i].has_exp, rows[i].exp_r);
      drain();
      csr_write(REG_RAMP_INTERVAL, 1); csr_write(REG_RAMP_STEP, 100);
      csr_write(REG_MIN_SPEED, 0); csr_write(REG_FORWARD_LEVEL, 0);
      csr_write(REG_ENC_REVERSE, 1);
      random_run(500);
      drain();
      csr_write(REG_RAMP_INTERVAL, 0); csr_write(REG_RAMP_STEP, 7);
      csr_write(REG_MIN_SPEED, 127); csr_write(REG_ENC_REVERSE, 0);
      random_run(400);
      drain();
      csr_write(REG_RAMP_INTERVAL, 1000); csr_write(REG_RAMP_STEP, 1);
      csr_write(REG_MIN_SPEED, 100); csr_write(REG_FORWARD_LEVEL, 1);
      random_run(300);
      drain();
      csr_write(REG_RAMP_INTERVAL, 3); csr_write(REG_RAMP_STEP, 5);
      csr_write(REG_MIN_SPEED, 15);
      random_run(450);
      quiet = 1;
      random_run(275);
      drain();
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire

/* motor_motion_profile_ramp.f */
sv/mmpr_pkg.sv
sv/motor_motion_profile_ramp.sv
tb/tb.sv
